>>> design/assert_macros.svh
// Assertion macros used by the checker file of the IMU frame rotation block.
// Needs clk_i and rst_ni visible in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// Check that a condition implies another at the same edge.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`endif

>>> design/imufr_pkg.sv
// Package for the IMU frame rotation block: constants, register codes and types.
// No dependencies; used by every module of the block but the queue.
package imufr_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam int QUAT_W     = 16;
  localparam int QUAT_FRAC  = 14;
  localparam int PROD_W     = 34;  // exact Hamilton product, Q4.28 plus headroom
  localparam int MAG_W      = 30;  // magnitude after normalising shift
  localparam int SQ_W       = 64;  // square root working width
  localparam int ROOT_W     = 32;
  localparam int SQ_STAGES  = 32;
  localparam int DIV_STAGES = 15;
  localparam int NUM_W      = 46;
  localparam int QUEUE_DEPTH = 2;

  // accept edge to result edge
  localparam int LATENCY = 5 + SQ_STAGES + DIV_STAGES + 2;

  localparam logic [47:0] ROW0_RST  = 48'h2F8F_0000_2AD3;
  localparam logic [47:0] ROW1_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] ROW2_RST  = 48'h2AD3_0000_D071;
  localparam logic [63:0] MOUNT_RST = 64'h3A77_0000_19F8_0000;

  typedef enum logic [1:0] {
    REG_ROW0  = 2'd0,
    REG_ROW1  = 2'd1,
    REG_ROW2  = 2'd2,
    REG_MOUNT = 2'd3
  } cfg_idx_e;

  // quaternion word as classified by the front end
  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
    logic                  zero;
  } quat_cls_t;

endpackage

>>> design/imufr_queue.sv
// Short word queue between the front and back ends of the IMU frame rotation block.
// Generic in width and depth; no package dependency.
module imufr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> design/imufr_front.sv
// Front end of the IMU frame rotation block: configuration registers, matrix and
// Hamilton products, rounding and saturation, quaternion classification. Uses imufr_pkg.
module imufr_front #(
  parameter int SAMPLE_WIDTH   = imufr_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = imufr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  input  logic signed [15:0]            quat_in_x_i,
  input  logic signed [15:0]            quat_in_y_i,
  input  logic signed [15:0]            quat_in_z_i,
  input  logic signed [15:0]            quat_in_w_i,
  output logic                          push_o,
  output logic [6*SAMPLE_WIDTH-1:0]     vec_o,
  output imufr_pkg::quat_cls_t          cls_o
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int VP_W   = SW + 16;
  localparam int ACC_W  = (SW + 18 > COEF_FRAC_BITS + 2) ? SW + 18 : COEF_FRAC_BITS + 2;
  localparam int PW     = imufr_pkg::PROD_W;
  localparam int MW     = imufr_pkg::MAG_W;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

  logic [47:0] row_q [3];
  logic [63:0] mount_q;

  logic signed [15:0]   coef  [3][3];
  logic signed [15:0]   mq    [4];
  logic signed [15:0]   qin   [4];
  logic signed [SW-1:0] smp   [2][3];
  logic                 accept;

  logic signed [VP_W-1:0] vp_q [2][3][3];
  logic signed [31:0]     qp_q [4][4];
  logic                   f1_v_q;

  logic [6*SW-1:0]        vec_d, vec_q;
  logic signed [PW-1:0]   p_d [4];
  logic signed [PW-1:0]   p_q [4];
  logic                   f2_v_q;

  logic signed [ACC_W-1:0] acc, rnd_sh, sat;
  logic [PW-1:0]           mag [4];
  logic [PW-1:0]           orr;
  logic [1:0]              kshift;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= imufr_pkg::ROW0_RST;
      row_q[1] <= imufr_pkg::ROW1_RST;
      row_q[2] <= imufr_pkg::ROW2_RST;
      mount_q  <= imufr_pkg::MOUNT_RST;
    end else if (cfg_we_i) begin
      case (imufr_pkg::cfg_idx_e'(cfg_idx_i))
        imufr_pkg::REG_ROW0:  row_q[0] <= cfg_wdata_i[47:0];
        imufr_pkg::REG_ROW1:  row_q[1] <= cfg_wdata_i[47:0];
        imufr_pkg::REG_ROW2:  row_q[2] <= cfg_wdata_i[47:0];
        imufr_pkg::REG_MOUNT: mount_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = $signed(row_q[r][16*c +: 16]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      mq[i] = $signed(mount_q[16*i +: 16]);
    end
  end

  assign qin[0] = quat_in_x_i;
  assign qin[1] = quat_in_y_i;
  assign qin[2] = quat_in_z_i;
  assign qin[3] = quat_in_w_i;
  assign smp[0][0] = gyro_x_i;
  assign smp[0][1] = gyro_y_i;
  assign smp[0][2] = gyro_z_i;
  assign smp[1][0] = accel_x_i;
  assign smp[1][1] = accel_y_i;
  assign smp[1][2] = accel_z_i;

  assign accept = start_i && !busy_i;

  // stage 1: all products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int s = 0; s < 2; s++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            vp_q[s][r][c] <= coef[r][c] * smp[s][c];
          end
        end
      end
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          qp_q[i][j] <= mq[i] * qin[j];
        end
      end
    end
  end

  // stage 2: round, saturate, sum the Hamilton terms
  always_comb begin
    vec_d  = '0;
    acc    = '0;
    rnd_sh = '0;
    sat    = '0;
    for (int s = 0; s < 2; s++) begin
      for (int r = 0; r < 3; r++) begin
        acc = ACC_W'(vp_q[s][r][0]) + ACC_W'(vp_q[s][r][1]) + ACC_W'(vp_q[s][r][2]);
        rnd_sh = (acc + RND) >>> COEF_FRAC_BITS;
        if (rnd_sh > SMAX) begin
          sat = SMAX;
        end else if (rnd_sh < SMIN) begin
          sat = SMIN;
        end else begin
          sat = rnd_sh;
        end
        vec_d[(s*3+r)*SW +: SW] = sat[SW-1:0];
      end
    end
    p_d[3] = PW'(qp_q[3][3]) - PW'(qp_q[0][0]) - PW'(qp_q[1][1]) - PW'(qp_q[2][2]);
    p_d[0] = PW'(qp_q[3][0]) + PW'(qp_q[0][3]) + PW'(qp_q[1][2]) - PW'(qp_q[2][1]);
    p_d[1] = PW'(qp_q[3][1]) - PW'(qp_q[0][2]) + PW'(qp_q[1][3]) + PW'(qp_q[2][0]);
    p_d[2] = PW'(qp_q[3][2]) + PW'(qp_q[0][1]) - PW'(qp_q[1][0]) + PW'(qp_q[2][3]);
  end

  always_ff @(posedge clk_i) begin
    if (f1_v_q) begin
      vec_q <= vec_d;
      p_q   <= p_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      f1_v_q <= accept;
      f2_v_q <= f1_v_q;
    end
  end

  // classify: magnitudes, common shift below 2^30, zero detect
  always_comb begin
    orr = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = p_q[i][PW-1] ? PW'(-p_q[i]) : PW'(p_q[i]);
      orr    = orr | mag[i];
    end
    if (orr[32]) begin
      kshift = 2'd3;
    end else if (orr[31]) begin
      kshift = 2'd2;
    end else if (orr[30]) begin
      kshift = 2'd1;
    end else begin
      kshift = 2'd0;
    end
    for (int i = 0; i < 4; i++) begin
      cls_o.mag[i] = MW'(mag[i] >> kshift);
      cls_o.neg[i] = p_q[i][PW-1];
    end
    cls_o.zero = (orr == '0);
  end

  assign push_o = f2_v_q;
  assign vec_o  = vec_q;

endmodule

>>> design/imufr_back.sv
// Back end of the IMU frame rotation block: sum of squares, pipelined square root,
// pipelined dividers and output register. Uses imufr_pkg.
module imufr_back #(
  parameter int SAMPLE_WIDTH = imufr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [6*SAMPLE_WIDTH-1:0] vec_i,
  input  imufr_pkg::quat_cls_t      cls_i,
  output logic                      done_o,
  output logic [6*SAMPLE_WIDTH-1:0] vec_o,
  output logic [3:0][15:0]          quat_o,
  output logic                      zero_o
);

  localparam int SQ  = imufr_pkg::SQ_STAGES;
  localparam int DV  = imufr_pkg::DIV_STAGES;
  localparam int SW2 = imufr_pkg::SQ_W;
  localparam int RW  = imufr_pkg::ROOT_W;
  localparam int NW  = imufr_pkg::NUM_W;
  localparam int MW  = imufr_pkg::MAG_W;
  localparam int QW  = imufr_pkg::QUAT_W;

  typedef struct packed {
    logic [6*SAMPLE_WIDTH-1:0] vec;
    imufr_pkg::quat_cls_t      cls;
  } carry_t;

  logic [2*MW-1:0] sq_q [4];
  carry_t          b1_c_q;
  logic            b1_v_q;

  logic [SW2-1:0] rt_s_q [SQ+1];
  logic [SW2-1:0] rt_r_q [SQ+1];
  carry_t         rt_c_q [SQ+1];
  logic           rt_v_q [SQ+1];

  logic [NW-1:0]   dv_rem_q [DV+1][4];
  logic [DV-1:0]   dv_quo_q [DV+1][4];
  logic [RW-1:0]   dv_n_q   [DV+1];
  carry_t          dv_c_q   [DV+1];
  logic            dv_v_q   [DV+1];

  logic [RW-1:0] root;
  logic          out_v_q;

  assign root = rt_r_q[SQ][RW-1:0];

  // squares, then their sum
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= cls_i.mag[i] * cls_i.mag[i];
      end
      b1_c_q <= '{vec: vec_i, cls: cls_i};
    end
    if (b1_v_q) begin
      rt_s_q[0] <= SW2'(sq_q[0]) + SW2'(sq_q[1]) + SW2'(sq_q[2]) + SW2'(sq_q[3]);
      rt_r_q[0] <= '0;
      rt_c_q[0] <= b1_c_q;
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    localparam logic [SW2-1:0] BITC = SW2'(1) << (SW2 - 2 - 2 * i);
    logic [SW2-1:0] trial;
    assign trial = rt_r_q[i] + BITC;
    always_ff @(posedge clk_i) begin
      if (rt_v_q[i]) begin
        if (rt_s_q[i] >= trial) begin
          rt_s_q[i+1] <= rt_s_q[i] - trial;
          rt_r_q[i+1] <= (rt_r_q[i] >> 1) + BITC;
        end else begin
          rt_s_q[i+1] <= rt_s_q[i];
          rt_r_q[i+1] <= rt_r_q[i] >> 1;
        end
        rt_c_q[i+1] <= rt_c_q[i];
      end
    end
  end

  // numerators with half the norm added for rounding
  always_ff @(posedge clk_i) begin
    if (rt_v_q[SQ]) begin
      for (int l = 0; l < 4; l++) begin
        dv_rem_q[0][l] <= {NW'(rt_c_q[SQ].cls.mag[l]) << imufr_pkg::QUAT_FRAC}
                          + NW'(root >> 1);
        dv_quo_q[0][l] <= '0;
      end
      dv_n_q[0] <= root;
      dv_c_q[0] <= rt_c_q[SQ];
    end
  end

  // restoring division, one quotient bit per stage, four lanes
  for (genvar j = 0; j < DV; j++) begin : g_div
    localparam int B = DV - 1 - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(dv_n_q[j]) << B;
    always_ff @(posedge clk_i) begin
      if (dv_v_q[j]) begin
        for (int l = 0; l < 4; l++) begin
          if (dv_rem_q[j][l] >= dsh) begin
            dv_rem_q[j+1][l] <= dv_rem_q[j][l] - dsh;
            dv_quo_q[j+1][l] <= dv_quo_q[j][l] | (DV'(1) << B);
          end else begin
            dv_rem_q[j+1][l] <= dv_rem_q[j][l];
            dv_quo_q[j+1][l] <= dv_quo_q[j][l];
          end
        end
        dv_n_q[j+1] <= dv_n_q[j];
        dv_c_q[j+1] <= dv_c_q[j];
      end
    end
  end

  // apply signs, force zero on a zero-length product
  always_ff @(posedge clk_i) begin
    if (dv_v_q[DV]) begin
      vec_o  <= dv_c_q[DV].vec;
      zero_o <= dv_c_q[DV].cls.zero;
      for (int l = 0; l < 4; l++) begin
        if (dv_c_q[DV].cls.zero) begin
          quat_o[l] <= '0;
        end else if (dv_c_q[DV].cls.neg[l]) begin
          quat_o[l] <= -QW'(dv_quo_q[DV][l]);
        end else begin
          quat_o[l] <= QW'(dv_quo_q[DV][l]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i <= SQ; i++) begin
        rt_v_q[i] <= 1'b0;
      end
      for (int j = 0; j <= DV; j++) begin
        dv_v_q[j] <= 1'b0;
      end
    end else begin
      b1_v_q    <= valid_i;
      rt_v_q[0] <= b1_v_q;
      for (int i = 0; i < SQ; i++) begin
        rt_v_q[i+1] <= rt_v_q[i];
      end
      dv_v_q[0] <= rt_v_q[SQ];
      for (int j = 0; j < DV; j++) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
      out_v_q <= dv_v_q[DV];
    end
  end

  assign done_o = out_v_q;

endmodule

>>> design/imu_frame_rotation.sv
// Top level of the IMU frame rotation block: front end, word queue, back end.
// Depends on imufr_pkg, imufr_front, imufr_queue and imufr_back.
//
// One sample word is taken per clock (start_i while busy_o is low) and each
// result appears on the output ports for exactly one cycle with done_o high;
// results leave in the order samples came in. The latency is set by the
// 32-stage square root that forms the quaternion norm and the 15-stage
// divider that scales each component; the front end adds two product/sum
// stages, the queue one, and the back end four more: the squares, their sum,
// the rounded numerators and the output register. The receiver cannot stall,
// so the back end runs every cycle and the queue between front and back never
// fills: busy_o stays low in normal operation. Write the configuration
// registers only while no sample is in flight.
module imu_frame_rotation #(
  parameter int SAMPLE_WIDTH   = imufr_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = imufr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [63:0]                    cfg_wdata_i,
  // sample word
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  input  logic signed [15:0]             quat_in_x_i,
  input  logic signed [15:0]             quat_in_y_i,
  input  logic signed [15:0]             quat_in_z_i,
  input  logic signed [15:0]             quat_in_w_i,
  // result word
  output logic                           done_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_gyro_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_gyro_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_gyro_z_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_accel_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_accel_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_accel_z_o,
  output logic signed [15:0]             quat_out_x_o,
  output logic signed [15:0]             quat_out_y_o,
  output logic signed [15:0]             quat_out_z_o,
  output logic signed [15:0]             quat_out_w_o,
  output logic                           zero_norm_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CLS_W = $bits(imufr_pkg::quat_cls_t);
  localparam int QWD_W = 6 * SW + CLS_W;

  logic                  fr_push;
  logic [6*SW-1:0]       fr_vec, bk_vec_in, bk_vec;
  imufr_pkg::quat_cls_t  fr_cls, bk_cls;
  logic [QWD_W-1:0]      q_rdata;
  logic                  q_empty, q_full;
  logic [3:0][15:0]      bk_quat;

  // front end: registers, products, classification
  imufr_front #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_i      (q_full),
    .gyro_x_i    (gyro_x_i),
    .gyro_y_i    (gyro_y_i),
    .gyro_z_i    (gyro_z_i),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .quat_in_x_i (quat_in_x_i),
    .quat_in_y_i (quat_in_y_i),
    .quat_in_z_i (quat_in_z_i),
    .quat_in_w_i (quat_in_w_i),
    .push_o      (fr_push),
    .vec_o       (fr_vec),
    .cls_o       (fr_cls)
  );

  // hold classified words until the back end takes them
  imufr_queue #(
    .WIDTH (QWD_W),
    .DEPTH (imufr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .wdata_i ({fr_vec, fr_cls}),
    .pop_i   (!q_empty),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign bk_vec_in = q_rdata[QWD_W-1 -: 6*SW];
  assign bk_cls    = imufr_pkg::quat_cls_t'(q_rdata[CLS_W-1:0]);

  // back end: norm, scaling, output register; advances every cycle
  imufr_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!q_empty),
    .vec_i   (bk_vec_in),
    .cls_i   (bk_cls),
    .done_o  (done_o),
    .vec_o   (bk_vec),
    .quat_o  (bk_quat),
    .zero_o  (zero_norm_o)
  );

  assign busy_o = q_full;

  assign rot_gyro_x_o  = bk_vec[0*SW +: SW];
  assign rot_gyro_y_o  = bk_vec[1*SW +: SW];
  assign rot_gyro_z_o  = bk_vec[2*SW +: SW];
  assign rot_accel_x_o = bk_vec[3*SW +: SW];
  assign rot_accel_y_o = bk_vec[4*SW +: SW];
  assign rot_accel_z_o = bk_vec[5*SW +: SW];
  assign quat_out_x_o  = bk_quat[0];
  assign quat_out_y_o  = bk_quat[1];
  assign quat_out_z_o  = bk_quat[2];
  assign quat_out_w_o  = bk_quat[3];

endmodule

>>> design/imufr_checker.sv
// Port-level checks for the IMU frame rotation block, bound to its top level.
// Depends on imufr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imufr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic               zero_norm_o,
  input logic signed [15:0] quat_out_x_o,
  input logic signed [15:0] quat_out_y_o,
  input logic signed [15:0] quat_out_z_o,
  input logic signed [15:0] quat_out_w_o
);

  // queue drains every cycle, so it never fills
  `ASSERT_ALWAYS(a_never_busy, !busy_o, "busy raised although the back end never stalls")

  // every result stems from a word taken a fixed latency earlier
  `ASSERT_IMPL(a_latency, done_o, $past(start_i && !busy_o, imufr_pkg::LATENCY), "result without matching sample")

  `ASSERT_IMPL(a_zero_out, done_o && zero_norm_o, quat_out_x_o == 16'sd0 && quat_out_y_o == 16'sd0 && quat_out_z_o == 16'sd0 && quat_out_w_o == 16'sd0, "zero norm with non-zero quaternion")

  `ASSERT_IMPL(a_unit_range, done_o, quat_out_x_o <= 16'sd16384 && quat_out_x_o >= -16'sd16384 && quat_out_w_o <= 16'sd16384 && quat_out_w_o >= -16'sd16384, "normalised component out of range")

endmodule

bind imu_frame_rotation imufr_checker u_imufr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .zero_norm_o  (zero_norm_o),
  .quat_out_x_o (quat_out_x_o),
  .quat_out_y_o (quat_out_y_o),
  .quat_out_z_o (quat_out_z_o),
  .quat_out_w_o (quat_out_w_o)
);
